[rtl/cic_pkg.sv]
// cascaded interrupt controller package: request codes, status codes, flag positions
// and the priority helper functions used by the rtl
// no dependencies
package cic_pkg;

	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_LINE  = 2'd2;
	localparam logic [1:0] REQ_ACK   = 2'd3;

	localparam logic [1:0] ACC_OK      = 2'd0;
	localparam logic [1:0] ACC_NODEC   = 2'd1;
	localparam logic [1:0] ACC_NONBYTE = 2'd2;

	localparam logic [1:0] LS_MASKED  = 2'd0;
	localparam logic [1:0] LS_PENDING = 2'd1;
	localparam logic [1:0] LS_NEW     = 2'd2;

	localparam int F_ICW4    = 0;
	localparam int F_AEOI    = 1;
	localparam int F_ROTATE  = 2;
	localparam int F_SFNM    = 3;
	localparam int F_POLL    = 4;
	localparam int F_READSEL = 5;

	localparam logic [7:0] MASTER_ELCR_RESET = 8'hf8;
	localparam logic [7:0] SLAVE_ELCR_RESET  = 8'hde;

	localparam logic [15:0] PORT_MASTER = 16'h0020;
	localparam logic [15:0] PORT_SLAVE  = 16'h00a0;
	localparam logic [15:0] PORT_ELCR   = 16'h04d0;

	localparam logic [2:0] CFG_MASTER_ELCR = 3'd0;
	localparam logic [2:0] CFG_SLAVE_ELCR  = 3'd1;

	// per-controller state
	typedef struct packed {
		logic [7:0] irr;
		logic [7:0] last;
		logic [7:0] isr;
		logic [7:0] imr;
		logic [7:0] elcr;
		logic [2:0] prio;
		logic [7:0] base;
		logic [1:0] step;
		logic [5:0] flags;
	} pic_t;

	// rank of the first set bit from the highest-priority offset; 8 if none
	function automatic logic [3:0] rank_of(input logic [7:0] m, input logic [2:0] off);
		logic [3:0] r;
		logic [2:0] idx;
		r = 4'd8;
		for (int p = 7; p >= 0; p--) begin
			idx = 3'(p) + off;
			if (m[idx]) r = 4'(p);
		end
		return r;
	endfunction

	// highest priority line that may interrupt, valid flag in bit 3
	function automatic logic [3:0] wanted(input pic_t s, input logic sfnm_master);
		logic [3:0] p;
		logic [3:0] cur;
		logic [7:0] m;
		p = rank_of(s.irr & ~s.imr, s.prio);
		m = s.isr;
		if (sfnm_master) m[2] = 1'b0;
		cur = rank_of(m, s.prio);
		if (p != 4'd8 && p < cur) return {1'b1, p[2:0] + s.prio};
		return 4'd0;
	endfunction

endpackage

[rtl/cascaded_interrupt_controller.sv]
// cascaded interrupt controller top level: master and slave 8259-style controllers
// uses cic_pkg
//
// usage:
//   request channel (in_valid / in_stall) carries one bus access, line change
//   or interrupt acknowledge per request; the result channel (out_valid /
//   out_stall) returns exactly one result per request
//   result: registered in the result register, or in the skid register
//   while the result waits; throughput one request per cycle while in_stall
//   is low; all work for a request is the combinational update of the
//   controller state registers, which lands in the same edge as the result or skid load
//   stall: when the result waits, a new request is still accepted into the
//   skid register; in_stall rises only when both result and skid hold data
//   reset: all controller state clears, the elcr write masks return to
//   0xf8 / 0xde, both channels empty
//   configuration: cfg_we with cfg_index 0 or 1 writes a mask; other
//   indexes are ignored
//   the state update is done at acceptance, so results keep request order
module cascaded_interrupt_controller
	import cic_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [15:0] port_addr,
	input  logic        byte_access,
	input  logic [7:0]  write_data,
	input  logic [3:0]  irq_line,
	input  logic        level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic [7:0]  vector,
	output logic [1:0]  access_status,
	output logic [1:0]  line_status,
	output logic        int_out,
	output logic        wakeup_pulse
);

	typedef struct packed {
		logic [7:0] rd;
		logic [7:0] vec;
		logic [1:0] acc;
		logic [1:0] ls;
		logic       io;
		logic       wk;
	} res_t;

	logic [7:0] mmask_q, smask_q;
	pic_t       pic_q [2];
	logic       cpu_q;
	res_t       out_q, skid_q, res_d;
	logic       ov_q, sv_q;
	logic       accept;

	pic_t       p_d [2];
	logic       cpu_d;

	// two-entry output: result register plus skid
	assign in_stall = sv_q;
	assign accept   = in_valid && !sv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mmask_q <= MASTER_ELCR_RESET;
			smask_q <= SLAVE_ELCR_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MASTER_ELCR) mmask_q <= cfg_data;
			else if (cfg_index == CFG_SLAVE_ELCR) smask_q <= cfg_data;
		end
	end

	// one-shot update of the whole pair for the accepted request
	always_comb begin
		pic_t s [2];
		logic cpu;
		logic pulse;
		logic [3:0] w;
		logic [3:0] w2;
		logic [3:0] pr;
		logic [7:0] bm;
		logic [2:0] b;
		logic [2:0] cmd;
		logic c;
		logic odd;
		logic decoded;
		logic do_ref;
		logic res;
		s = pic_q;
		cpu = cpu_q;
		pulse = 1'b0;
		res_d = '0;
		do_ref = 1'b0;
		w = '0; w2 = '0; pr = '0; bm = '0; b = '0; cmd = '0; c = 1'b0; res = 1'b0;
		odd = port_addr[0];
		decoded = port_addr == PORT_MASTER || port_addr == (PORT_MASTER | 16'd1) ||
			port_addr == PORT_SLAVE || port_addr == (PORT_SLAVE | 16'd1) ||
			port_addr == PORT_ELCR || port_addr == (PORT_ELCR | 16'd1);
		case (req_type)
			REQ_READ, REQ_WRITE: begin
				if (!decoded) res_d.acc = ACC_NODEC;
				else if (!byte_access) res_d.acc = ACC_NONBYTE;
				else if (port_addr[10]) begin
					c = odd;
					if (req_type == REQ_WRITE)
						s[c].elcr = write_data & (c ? smask_q : mmask_q);
					else res_d.rd = s[c].elcr;
				end else begin
					c = port_addr[7];
					if (req_type == REQ_WRITE) begin
						if (!odd) begin
							if (write_data[4]) begin
								s[c].flags[F_ICW4] = write_data[0];
								s[c].last = '0;
								s[c].irr = s[c].irr & s[c].elcr;
								s[c].imr = '0;
								s[c].prio = '0;
								s[c].flags[F_READSEL] = 1'b0;
								if (!write_data[0]) begin
									s[c].flags[F_SFNM] = 1'b0;
									s[c].flags[F_AEOI] = 1'b0;
								end
								s[c].step = 2'd1;
							end else if (write_data[3]) begin
								if (write_data[2]) s[c].flags[F_POLL] = 1'b1;
								if (write_data[1]) s[c].flags[F_READSEL] = write_data[0];
							end else begin
								cmd = write_data[7:5];
								case (cmd)
									3'd0, 3'd4: s[c].flags[F_ROTATE] = cmd[2];
									3'd1, 3'd5: begin
										pr = rank_of(s[c].isr, s[c].prio);
										if (pr != 4'd8) begin
											b = pr[2:0] + s[c].prio;
											if (cmd[2]) s[c].prio = b + 3'd1;
											s[c].isr[b] = 1'b0;
											do_ref = 1'b1;
										end
									end
									3'd3: begin
										s[c].isr[write_data[2:0]] = 1'b0;
										do_ref = 1'b1;
									end
									3'd6: begin
										s[c].prio = write_data[2:0] + 3'd1;
										do_ref = 1'b1;
									end
									3'd7: begin
										s[c].prio = write_data[2:0] + 3'd1;
										s[c].isr[write_data[2:0]] = 1'b0;
										do_ref = 1'b1;
									end
									default: ;
								endcase
							end
						end else begin
							case (s[c].step)
								2'd0: begin
									s[c].imr = write_data;
									do_ref = 1'b1;
								end
								2'd1: begin
									s[c].base = {write_data[7:3], 3'd0};
									s[c].step = 2'd2;
								end
								2'd2: s[c].step = s[c].flags[F_ICW4] ? 2'd3 : 2'd0;
								default: begin
									s[c].flags[F_SFNM] = write_data[4];
									s[c].flags[F_AEOI] = write_data[1];
									s[c].step = 2'd0;
								end
							endcase
						end
					end else begin
						if (s[c].flags[F_POLL]) begin
							w = wanted(s[c], !c && s[0].flags[F_SFNM]);
							if (w[3]) begin
								if (c) begin
									s[0].isr[2] = 1'b0;
									s[0].irr[2] = 1'b0;
								end
								s[c].irr[w[2:0]] = 1'b0;
								s[c].isr[w[2:0]] = 1'b0;
								do_ref = c || w[2:0] != 3'd2;
								res_d.rd = {5'd0, w[2:0]};
							end else begin
								do_ref = 1'b1;
								res_d.rd = 8'd7;
							end
							s[c].flags[F_POLL] = 1'b0;
						end else if (!odd)
							res_d.rd = s[c].flags[F_READSEL] ? s[c].isr : s[c].irr;
						else res_d.rd = s[c].imr;
					end
				end
			end
			REQ_LINE: begin
				c = irq_line[3];
				b = irq_line[2:0];
				bm = 8'd1 << b;
				res = 1'b1;
				if (|(s[c].elcr & bm)) begin
					if (level) begin
						res = !(|(s[c].irr & bm));
						s[c].irr = s[c].irr | bm;
						s[c].last = s[c].last | bm;
					end else begin
						s[c].irr = s[c].irr & ~bm;
						s[c].last = s[c].last & ~bm;
					end
				end else if (level) begin
					if (!(|(s[c].last & bm))) begin
						res = !(|(s[c].irr & bm));
						s[c].irr = s[c].irr | bm;
					end
					s[c].last = s[c].last | bm;
				end else s[c].last = s[c].last & ~bm;
				if (|(s[c].imr & bm)) res_d.ls = LS_MASKED;
				else res_d.ls = res ? LS_NEW : LS_PENDING;
				do_ref = 1'b1;
			end
			default: begin
				w = wanted(s[0], s[0].flags[F_SFNM]);
				if (w[3]) begin
					b = w[2:0];
					s[0].isr[b] = 1'b1;
					if (!s[0].elcr[b]) s[0].irr[b] = 1'b0;
					if (s[0].flags[F_AEOI]) begin
						if (s[0].flags[F_ROTATE]) s[0].prio = b + 3'd1;
						s[0].isr[b] = 1'b0;
					end
					if (b == 3'd2) begin
						w2 = wanted(s[1], 1'b0);
						if (w2[3]) begin
							s[1].isr[w2[2:0]] = 1'b1;
							if (!s[1].elcr[w2[2:0]]) s[1].irr[w2[2:0]] = 1'b0;
							if (s[1].flags[F_AEOI]) begin
								if (s[1].flags[F_ROTATE]) s[1].prio = w2[2:0] + 3'd1;
								s[1].isr[w2[2:0]] = 1'b0;
							end
							res_d.vec = s[1].base + {5'd0, w2[2:0]};
						end else res_d.vec = s[1].base + 8'd7;
					end else res_d.vec = s[0].base + {5'd0, b};
				end else res_d.vec = s[0].base + 8'd7;
				do_ref = 1'b1;
			end
		endcase
		// cascade the slave onto master input 2 and recompute the cpu line
		if (do_ref) begin
			w2 = wanted(s[1], 1'b0);
			if (w2[3]) begin
				if (s[0].elcr[2]) begin
					s[0].irr[2] = 1'b0;
					s[0].last[2] = 1'b0;
				end else begin
					if (!s[0].last[2]) s[0].irr[2] = 1'b1;
					s[0].last[2] = 1'b0;
				end
			end
			pulse = !cpu;
			w = wanted(s[0], s[0].flags[F_SFNM]);
			cpu = w[3];
		end
		res_d.io = cpu;
		res_d.wk = pulse;
		p_d = s;
		cpu_d = cpu;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pic_q <= '{default: '0};
			cpu_q <= 1'b0;
		end else if (accept) begin
			pic_q <= p_d;
			cpu_q <= cpu_d;
		end
	end

	// result register with a skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else begin
			if (!ov_q || !out_stall) begin
				ov_q <= sv_q || accept;
				sv_q <= 1'b0;
			end else if (accept) sv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ov_q || !out_stall) out_q <= sv_q ? skid_q : res_d;
		if (accept && ov_q && out_stall) skid_q <= res_d;
	end

	assign out_valid     = ov_q;
	assign read_data     = out_q.rd;
	assign vector        = out_q.vec;
	assign access_status = out_q.acc;
	assign line_status   = out_q.ls;
	assign int_out       = out_q.io;
	assign wakeup_pulse  = out_q.wk;

endmodule

[rtl/cic_checker.sv]
// port-level checker for the cascaded interrupt controller
// uses cic_pkg; bound to cascaded_interrupt_controller
module cic_checker
	import cic_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] access_status,
	input logic [1:0] line_status,
	input logic       int_out,
	input logic       wakeup_pulse
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(int_out) && $stable(access_status)
			&& $stable(wakeup_pulse))
		else $error("stalled result changed");

	// status codes stay in range
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> access_status != 2'd3 && line_status != 2'd3)
		else $error("status code out of range");

	// a new request is never refused while the result slot is free
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("stall with empty output");

	// out_valid is set in the cycle after a request is accepted
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("missing result");

endmodule

bind cascaded_interrupt_controller cic_checker u_cic_checker (.*);
